// ===== sv/tcl_pkg.sv =====
// Shared types and constants for the timer with counter latch.
// Holds the item structure, operation codes and the register map.
// No dependencies; every other file imports this package.
package tcl_pkg;

	// Operation carried by one input item.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} tcl_op_t;

	// Register byte offsets.
	localparam logic [7:0] OFF_IRQ_EN  = 8'h00;
	localparam logic [7:0] OFF_IRQ_ST  = 8'h04;
	localparam logic [7:0] OFF_CTL     = 8'h10;
	localparam logic [7:0] OFF_INTVAL  = 8'h14;
	localparam logic [7:0] OFF_CNTVAL  = 8'h18;
	localparam logic [7:0] OFF_C64_CTL = 8'ha0;
	localparam logic [7:0] OFF_C64_LO  = 8'ha4;
	localparam logic [7:0] OFF_C64_HI  = 8'ha8;

	// Bit positions within the control registers.
	localparam int unsigned CTL_EN_BIT      = 0;
	localparam int unsigned CTL_RELOAD_BIT  = 1;
	localparam int unsigned CTL_ONESHOT_BIT = 7;
	localparam int unsigned C64_CLEAR_BIT   = 0;
	localparam int unsigned C64_LATCH_BIT   = 1;

	// One input item as held in the input register.
	typedef struct packed {
		tcl_op_t     op;
		logic [7:0]  reg_offset;
		logic [31:0] write_data;
	} tcl_item_t;

endpackage

// ===== sv/tcl_regs.sv =====
// Register file and counting logic of the timer with counter latch.
// Applies one item per cycle when fire is high; gives read data and the interrupt.
// Depends on tcl_pkg.
module tcl_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tcl_pkg::tcl_item_t item,
	output logic [31:0]       read_data,
	output logic              irq_line
);
	import tcl_pkg::*;

	logic        irq_en_q, irq_en_d;
	logic        irq_pend_q, irq_pend_d;
	logic [7:0]  ctl_q, ctl_d;
	logic [31:0] interval_q, interval_d;
	logic [31:0] count_q, count_d;
	logic [6:0]  presc_q, presc_d;
	logic [63:0] free_q, free_d;
	logic [63:0] latch_q, latch_d;
	logic [6:0]  presc_limit;

	// Prescale limit is 2^shift - 1 for the current shift field.
	assign presc_limit = 7'((8'd1 << ctl_q[6:4]) - 8'd1);

	// Next-state logic for a tick or a register write.
	always_comb begin
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q;
		ctl_d      = ctl_q;
		interval_d = interval_q;
		count_d    = count_q;
		presc_d    = presc_q;
		free_d     = free_q;
		latch_d    = latch_q;
		case (item.op)
			OP_TICK: begin
				free_d = free_q + 64'd1;
				if (ctl_q[CTL_EN_BIT]) begin
					if (presc_q >= presc_limit) begin
						presc_d = 7'd0;
						// The count expires at zero or one.
						if (count_q <= 32'd1) begin
							irq_pend_d = 1'b1;
							if (ctl_q[CTL_ONESHOT_BIT]) begin
								count_d = 32'd0;
								ctl_d[CTL_EN_BIT] = 1'b0;
							end else begin
								count_d = interval_q;
							end
						end else begin
							count_d = count_q - 32'd1;
						end
					end else begin
						presc_d = presc_q + 7'd1;
					end
				end
			end
			OP_WRITE: begin
				unique case (item.reg_offset)
					OFF_IRQ_EN: irq_en_d = item.write_data[0];
					OFF_IRQ_ST: begin
						if (item.write_data[0]) irq_pend_d = 1'b0;
					end
					OFF_CTL: begin
						// Enabling from off, or a write that sets both enable and reload, restarts the count.
						if (item.write_data[CTL_EN_BIT] &&
						    (!ctl_q[CTL_EN_BIT] || item.write_data[CTL_RELOAD_BIT])) begin
							count_d = interval_q;
							presc_d = 7'd0;
						end
						ctl_d = item.write_data[7:0];
						ctl_d[CTL_RELOAD_BIT] = 1'b0;
					end
					OFF_INTVAL: interval_d = item.write_data;
					OFF_CNTVAL: count_d = item.write_data;
					OFF_C64_CTL: begin
						// Clear acts before latch, so both together latch zero.
						if (item.write_data[C64_CLEAR_BIT]) free_d = 64'd0;
						if (item.write_data[C64_LATCH_BIT]) begin
							latch_d = item.write_data[C64_CLEAR_BIT] ? 64'd0 : free_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Read decode works on the state before the item.
	always_comb begin
		read_data = 32'd0;
		if (item.op == OP_READ) begin
			unique case (item.reg_offset)
				OFF_IRQ_EN: read_data = {31'd0, irq_en_q};
				OFF_IRQ_ST: read_data = {31'd0, irq_pend_q};
				OFF_CTL:    read_data = {24'd0, ctl_q};
				OFF_INTVAL: read_data = interval_q;
				OFF_CNTVAL: read_data = count_q;
				OFF_C64_LO: read_data = latch_q[31:0];
				OFF_C64_HI: read_data = latch_q[63:32];
				default:    read_data = 32'd0;
			endcase
		end
	end

	// The interrupt reflects the state after the item.
	assign irq_line = irq_pend_d & irq_en_d;

	// State registers, updated only when an item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q   <= 1'b0;
			irq_pend_q <= 1'b0;
			ctl_q      <= 8'd0;
			interval_q <= 32'd0;
			count_q    <= 32'd0;
			presc_q    <= 7'd0;
			free_q     <= 64'd0;
			latch_q    <= 64'd0;
		end else if (fire) begin
			irq_en_q   <= irq_en_d;
			irq_pend_q <= irq_pend_d;
			ctl_q      <= ctl_d;
			interval_q <= interval_d;
			count_q    <= count_d;
			presc_q    <= presc_d;
			free_q     <= free_d;
			latch_q    <= latch_d;
		end
	end

endmodule

// ===== sv/timer_with_counter_latch.sv =====
// Top level of the timer with counter latch: input register, register file, result register.
// Depends on tcl_pkg and tcl_regs.
// Each item is a bus read, a bus write, one source-clock tick or no operation, and yields one result.
//
// Throughput is one item per clock cycle while the result side does not stall: an item waits in
// the input register, is applied to the register file and its result is captured in the result
// register, from which it can be taken. A stalled result holds the result register; the input
// register still takes one further item before req_stall rises.
// The interrupt bit returned with each item is status AND enable after that item.
module timer_with_counter_latch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  reg_offset,
	input  logic [31:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] read_data,
	output logic        irq_line
);
	import tcl_pkg::*;

	logic        valid_s1;
	tcl_item_t   item_s1;
	logic        fire;
	logic [31:0] rd_next;
	logic        irq_next;
	logic [31:0] read_data_s2;
	logic        irq_s2;

	// The held item moves on whenever the result register is free or being emptied.
	assign fire      = valid_s1 & (~rsp_valid | ~rsp_stall);
	assign req_stall = valid_s1 & ~fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.op         <= tcl_op_t'(op);
			item_s1.reg_offset <= reg_offset;
			item_s1.write_data <= write_data;
		end
	end

	tcl_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.read_data (rd_next),
		.irq_line  (irq_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (fire) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_s2 <= rd_next;
			irq_s2       <= irq_next;
		end
	end

	assign read_data = read_data_s2;
	assign irq_line  = irq_s2;

`ifndef SYNTHESIS
	// A processed item always leaves a result behind.
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("processed item produced no result");

	// Only a read can return non-zero data.
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.op != OP_READ) |=> (read_data == 32'd0))
		else $error("non-read item returned data");

	// A waiting result with a full input register must back-pressure the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall && valid_s1) |-> req_stall)
		else $error("input not stalled while both stages are full");
`endif

endmodule

// ===== tb/sv/tcl_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the timer with counter latch: watches both channels, predicts every result.
// Depends on tcl_pkg for the operation codes, register offsets and control bit positions.
module tcl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  reg_offset,
	input  logic [31:0] write_data,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] read_data,
	input  logic        irq_line,
	output int          fail_count,
	output int          outstanding,
	output int          tick_count,
	output int          read_count,
	output int          write_count,
	output int          expiry_count
);
	import tcl_pkg::*;

	localparam int unsigned PRESCALE_LSB = 4;

	typedef struct packed {
		logic [31:0] rd;
		logic        irq;
	} timer_result_t;

	// Our own copy of the timer state.
	logic        irq_en;
	logic        irq_pend;
	logic [7:0]  ctl_r;
	logic [31:0] interval_r;
	logic [31:0] count_r;
	logic [6:0]  pre_cnt;
	logic [63:0] free_cnt;
	logic [63:0] latch_cnt;

	timer_result_t expected_results[$];
	int fails, ticks, reads, writes, expiries;

	// Apply one item to the state copy and return the result it should produce.
	function automatic timer_result_t timer_apply(input tcl_op_t o, input logic [7:0] a,
			input logic [31:0] d);
		timer_result_t res;
		logic [7:0]    lim;
		logic [7:0]    nv;
		res = '0;
		case (o)
			OP_TICK: begin
				ticks++;
				free_cnt = free_cnt + 64'd1;
				if (ctl_r[CTL_EN_BIT]) begin
					lim = (8'd1 << ctl_r[PRESCALE_LSB +: 3]) - 8'd1;
					if ({1'b0, pre_cnt} >= lim) begin
						pre_cnt = '0;
						// A count of zero or one expires; otherwise it steps down.
						if (count_r <= 32'd1) begin
							expiries++;
							irq_pend = 1'b1;
							if (ctl_r[CTL_ONESHOT_BIT]) begin
								count_r = '0;
								ctl_r[CTL_EN_BIT] = 1'b0;
							end else begin
								count_r = interval_r;
							end
						end else begin
							count_r = count_r - 32'd1;
						end
					end else begin
						pre_cnt = pre_cnt + 7'd1;
					end
				end
			end
			OP_READ: begin
				reads++;
				case (a)
					OFF_IRQ_EN:  res.rd = {31'b0, irq_en};
					OFF_IRQ_ST:  res.rd = {31'b0, irq_pend};
					OFF_CTL:     res.rd = {24'b0, ctl_r};
					OFF_INTVAL:  res.rd = interval_r;
					OFF_CNTVAL:  res.rd = count_r;
					OFF_C64_CTL: res.rd = '0;
					OFF_C64_LO:  res.rd = latch_cnt[31:0];
					OFF_C64_HI:  res.rd = latch_cnt[63:32];
					default:     res.rd = '0;
				endcase
			end
			OP_WRITE: begin
				writes++;
				case (a)
					OFF_IRQ_EN: irq_en = d[0];
					OFF_IRQ_ST: begin
						if (d[0])
							irq_pend = 1'b0;
					end
					OFF_CTL: begin
						nv = d[7:0];
						// Enabling from off, or enabling with reload, restarts the count.
						if (nv[CTL_EN_BIT] && (!ctl_r[CTL_EN_BIT] || nv[CTL_RELOAD_BIT])) begin
							count_r = interval_r;
							pre_cnt = '0;
						end
						ctl_r = nv;
						ctl_r[CTL_RELOAD_BIT] = 1'b0;
					end
					OFF_INTVAL: interval_r = d;
					OFF_CNTVAL: count_r = d;
					OFF_C64_CTL: begin
						// Clear acts before latch, so both together latch zero.
						if (d[C64_CLEAR_BIT])
							free_cnt = '0;
						if (d[C64_LATCH_BIT])
							latch_cnt = free_cnt;
					end
					default: ;
				endcase
			end
			OP_NONE: ;
		endcase
		res.irq = irq_pend & irq_en;
		return res;
	endfunction

	// Predict on every accepted item and compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		timer_result_t want;
		if (!arst_n) begin
			irq_en = 1'b0;
			irq_pend = 1'b0;
			ctl_r = '0;
			interval_r = '0;
			count_r = '0;
			pre_cnt = '0;
			free_cnt = '0;
			latch_cnt = '0;
		end else begin
			if (req_valid && !req_stall)
				expected_results.push_back(timer_apply(tcl_op_t'(op), reg_offset, write_data));
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("Result arrived with no item outstanding (read_data %h)", read_data);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (read_data !== want.rd) begin
						$error("read_data: expected %h, got %h", want.rd, read_data);
						fails++;
					end
					if (irq_line !== want.irq) begin
						$error("irq_line: expected %b, got %b", want.irq, irq_line);
						fails++;
					end
				end
			end
		end
		fail_count   <= fails;
		outstanding  <= expected_results.size();
		tick_count   <= ticks;
		read_count   <= reads;
		write_count  <= writes;
		expiry_count <= expiries;
	end

endmodule

// ===== tb/sv/timer_with_counter_latch_test.sv =====
`timescale 1ns / 1ps
// Top of the timer with counter latch testbench: clock, reset, item stimulus and the verdict.
// Depends on tcl_pkg, the block timer_with_counter_latch and the result checker tcl_checker.
module timer_with_counter_latch_test;
	import tcl_pkg::*;

	localparam int unsigned PRESCALE_LSB = 4;
	localparam int          RANDOM_ITEMS = 1650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  op = OP_TICK;
	logic [7:0]  reg_offset = '0;
	logic [31:0] write_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] read_data;
	logic        irq_line;

	int fail_count, outstanding, tick_count, read_count, write_count, expiry_count;
	int items_sent = 0;
	bit no_idle = 1'b0;

	timer_with_counter_latch dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data),
		.irq_line   (irq_line)
	);

	tcl_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (op),
		.reg_offset   (reg_offset),
		.write_data   (write_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.read_data    (read_data),
		.irq_line     (irq_line),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.tick_count   (tick_count),
		.read_count   (read_count),
		.write_count  (write_count),
		.expiry_count (expiry_count)
	);

	always #1 clk = ~clk;

	// The result side stalls in about a quarter of cycles, except during the quiet stretch.
	always @(negedge clk) begin
		rsp_stall <= (arst_n && !no_idle) ? ($urandom_range(99) < 25) : 1'b0;
	end

	// Present one item, with random idle cycles ahead of it, and hold it until it is taken.
	task automatic send(input tcl_op_t o, input logic [7:0] a, input logic [31:0] d);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		op         <= o;
		reg_offset <= a;
		write_data <= d;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(7))
			0:       return OFF_IRQ_EN;
			1:       return OFF_IRQ_ST;
			2:       return OFF_CTL;
			3:       return OFF_INTVAL;
			4:       return OFF_CNTVAL;
			5:       return OFF_C64_CTL;
			6:       return OFF_C64_LO;
			default: return OFF_C64_HI;
		endcase
	endfunction

	// Mostly enabled, mostly short prescale; reload, one-shot and junk upper bits at random.
	function automatic logic [31:0] random_control();
		logic [31:0] v;
		v = $urandom();
		v[CTL_EN_BIT] = ($urandom_range(9) != 0);
		v[PRESCALE_LSB +: 3] = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
			: 3'($urandom_range(2));
		return v;
	endfunction

	initial begin
		int r;
		int burst;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Periodic expiry with the interrupt enabled, then clearing the status.
		send(OP_WRITE, OFF_IRQ_EN, 32'hFFFF_FFFF);
		send(OP_WRITE, OFF_INTVAL, 32'd2);
		send(OP_WRITE, OFF_CTL, 32'h0000_0001);
		send(OP_TICK, 8'h00, 32'h0);
		send(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
		send(OP_READ, OFF_IRQ_ST, 32'h0);
		send(OP_WRITE, OFF_IRQ_ST, 32'hFFFF_FFFE);
		send(OP_WRITE, OFF_IRQ_ST, 32'h0000_0001);
		// Prescale shortened mid-count: the step fires as soon as the limit is passed.
		send(OP_WRITE, OFF_CTL, 32'h0000_0021);
		send(OP_TICK, 8'h00, 32'h0);
		send(OP_TICK, 8'h00, 32'h0);
		send(OP_WRITE, OFF_CTL, 32'h0000_0011);
		send(OP_TICK, 8'h00, 32'h0);
		// One-shot expiry from a count of zero stops the timer.
		send(OP_WRITE, OFF_CNTVAL, 32'h0);
		send(OP_WRITE, OFF_CTL, 32'h0000_0081);
		send(OP_TICK, 8'h00, 32'h0);
		send(OP_READ, OFF_CTL, 32'h0);
		// All control bits set: reload, longest prescale, upper bits dropped.
		send(OP_WRITE, OFF_CTL, 32'hFFFF_FFFF);
		send(OP_READ, OFF_CTL, 32'h0);
		// Latch alone, then clear together with latch.
		send(OP_WRITE, OFF_C64_CTL, 32'h0000_0002);
		send(OP_READ, OFF_C64_LO, 32'h0);
		send(OP_READ, OFF_C64_HI, 32'h0);
		send(OP_WRITE, OFF_C64_CTL, 32'hFFFF_FFFF);
		send(OP_READ, OFF_C64_LO, 32'h0);
		// Unmapped offsets and the unused operation.
		send(OP_WRITE, 8'hFF, 32'hFFFF_FFFF);
		send(OP_READ, 8'hFF, 32'h0);
		send(OP_NONE, 8'hFF, 32'hFFFF_FFFF);

		// Hold off until every outstanding result has come back.
		@(negedge clk);
		req_valid <= 1'b0;
		wait (outstanding == 0);

		// Random part: mostly timer programming followed by activity, the rest noise.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			no_idle = (items_sent >= 700 && items_sent < 1000);
			if ($urandom_range(99) < 75) begin
				send(OP_WRITE, OFF_INTVAL,
					($urandom_range(19) == 0) ? $urandom() : $urandom_range(12));
				if ($urandom_range(3) == 0)
					send(OP_WRITE, OFF_CNTVAL, $urandom_range(15));
				send(OP_WRITE, OFF_IRQ_EN, $urandom());
				send(OP_WRITE, OFF_CTL, random_control());
				burst = $urandom_range(5, 40);
				repeat (burst) begin
					r = $urandom_range(99);
					if (r < 65)
						send(OP_TICK, 8'($urandom()), $urandom());
					else if (r < 82)
						send(OP_READ, pick_offset(), $urandom());
					else if (r < 88)
						send(OP_WRITE, OFF_IRQ_ST, $urandom());
					else if (r < 93)
						send(OP_WRITE, OFF_C64_CTL, $urandom());
					else if (r < 97)
						send(OP_WRITE, OFF_CTL, random_control());
					else
						send(OP_WRITE, OFF_CNTVAL, $urandom_range(6));
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send(($urandom_range(9) == 0) ? OP_NONE : tcl_op_t'($urandom_range(2)),
						($urandom_range(1) != 0) ? pick_offset() : 8'($urandom()),
						$urandom());
				end
			end
		end
		no_idle = 1'b0;

		// Drain and give the block a few more cycles for stray results.
		@(negedge clk);
		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(posedge clk);

		$display("Run covered %0d ticks, %0d reads and %0d writes; the timer expired %0d times.",
			tick_count, read_count, write_count, expiry_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#200_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/tcl_pkg.sv
sv/tcl_regs.sv
sv/timer_with_counter_latch.sv
tb/sv/tcl_checker.sv
tb/sv/timer_with_counter_latch_test.sv
